FILE: rtl/trp_pkg.sv
`default_nettype none
package trp_pkg;

  localparam int RES_MAX     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // result kinds
  localparam logic [3:0] KIND_SEC      = 4'd0;
  localparam logic [3:0] KIND_USEC     = 4'd1;
  localparam logic [3:0] KIND_ETH      = 4'd2;
  localparam logic [3:0] KIND_SRC_CHAR = 4'd3;
  localparam logic [3:0] KIND_SRC_END  = 4'd4;
  localparam logic [3:0] KIND_DST_CHAR = 4'd5;
  localparam logic [3:0] KIND_DST_END  = 4'd6;
  localparam logic [3:0] KIND_PORT     = 4'd7;
  localparam logic [3:0] KIND_PROTO    = 4'd8;
  localparam logic [3:0] KIND_LENGTH   = 4'd9;
  localparam logic [3:0] KIND_DATA     = 4'd10;
  localparam logic [3:0] KIND_FILL     = 4'd11;
  localparam logic [3:0] KIND_DONE     = 4'd12;
  localparam logic [3:0] KIND_ABORT    = 4'd13;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/trp_in_if.sv
`default_nettype none
interface trp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface
`default_nettype wire

FILE: rtl/trp_out_if.sv
`default_nettype none
interface trp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  result_kind;
  logic [63:0] result_value;
  logic        last_of_step;

  modport source (output valid, output result_kind, output result_value,
                  output last_of_step, input ready);
  modport sink (input valid, input result_kind, input result_value,
                input last_of_step, output ready);
endinterface
`default_nettype wire

FILE: rtl/trace_record_text_parser_core.sv
// channel  dir  payload                                    handshake
// text     in   text_byte[7:0], end_of_input               valid/ready
// result   out  result_kind[3:0], result_value[63:0],      valid/ready
//               last_of_step
//
// each text word is parsed in the cycle it is accepted; its 0 to 3 result
// words go into a four-entry queue and leave one per cycle from the next cycle
// while result ready is high. text is taken whenever the queue holds at most
// one word, so bytes that give one result also run at one word per cycle.
// rst is synchronous: record state returns to the seconds field, queue empties.
// a stalled result side fills the queue and then holds text ready low.
`default_nettype none
module trace_record_text_parser_core #(
  parameter int ADDR_MAX_CHARS = 46
) (
  input  wire logic clk,
  input  wire logic rst,
  trp_in_if.sink    text,
  trp_out_if.source result
);
  import trp_pkg::*;

  logic                  take;
  logic                  room;
  logic                  head_valid;
  logic [1:0]            res_count;
  result_t [RES_MAX-1:0] res;
  result_t               head;

  assign text.ready = room;
  assign take       = text.valid && room;

  trp_step #(
    .ADDR_MAX_CHARS(ADDR_MAX_CHARS)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .text_byte    (text.text_byte),
    .end_of_input (text.end_of_input),
    .res_count    (res_count),
    .res          (res)
  );

  trp_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (res_count),
    .push_data  (res),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (result.ready)
  );

  assign result.valid        = head_valid;
  assign result.result_kind  = head.kind;
  assign result.result_value = head.value;
  assign result.last_of_step = head.last;

endmodule
`default_nettype wire

FILE: rtl/trp_step.sv
`default_nettype none
module trp_step #(
  parameter int ADDR_MAX_CHARS = 46
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                take,
  input  wire logic [7:0]                          text_byte,
  input  wire logic                                end_of_input,
  output logic [1:0]                               res_count,
  output trp_pkg::result_t [trp_pkg::RES_MAX-1:0]  res
);
  import trp_pkg::*;

  typedef enum logic [3:0] {
    PH_SEC   = 4'd0,
    PH_USEC  = 4'd1,
    PH_ETH   = 4'd2,
    PH_SRC   = 4'd3,
    PH_DST   = 4'd4,
    PH_PORT  = 4'd5,
    PH_PROTO = 4'd6,
    PH_LEN   = 4'd7,
    PH_DATA  = 4'd8
  } phase_t;

  localparam logic [5:0] ADDR_LIMIT = 6'(ADDR_MAX_CHARS);

  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [5:0]  addr_count, addr_count_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic        nibble_seen, nibble_seen_next;
  logic [3:0]  high_nibble, high_nibble_next;

  logic        is_digit, is_hex, is_addr_char;
  logic [3:0]  hex_val;
  logic [63:0] acc_step;
  logic [31:0] rem_after;
  logic [3:0]  addr_kind;
  logic [1:0]  n;
  result_t [RES_MAX-1:0] list;

  always_comb begin
    is_digit = text_byte inside {[CH_ZERO:CH_NINE]};
    is_hex   = is_digit || (text_byte inside {[CH_UP_A:CH_UP_F], [CH_LO_A:CH_LO_F]});
    if (is_digit) begin
      hex_val = text_byte[3:0];
    end else begin
      // 'a'..'f' and 'A'..'F' share the low three bits: 1..6
      hex_val = 4'd9 + {1'b0, text_byte[2:0]};
    end
    is_addr_char = is_hex || (text_byte inside {CH_COLON, CH_DOT});
    // times ten as two shifted adds
    acc_step = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {60'd0, text_byte[3:0]};
    addr_kind = (phase == PH_SRC) ? KIND_SRC_CHAR : KIND_DST_CHAR;
    rem_after = nibble_seen ? data_remaining - 32'd1 : data_remaining;
  end

  always_comb begin
    phase_next          = phase;
    acc_next            = acc;
    addr_count_next     = addr_count;
    data_remaining_next = data_remaining;
    nibble_seen_next    = nibble_seen;
    high_nibble_next    = high_nibble;
    n                   = 2'd0;
    list                = '0;

    if (end_of_input) begin
      list[0]             = '{kind: KIND_ABORT, value: 64'd0, last: 1'b0};
      n                   = 2'd1;
      phase_next          = PH_SEC;
      acc_next            = '0;
      addr_count_next     = '0;
      data_remaining_next = '0;
      nibble_seen_next    = 1'b0;
      high_nibble_next    = '0;
    end else begin
      case (phase)
        PH_SRC, PH_DST: begin
          n = 2'd1;
          if (is_addr_char && addr_count < ADDR_LIMIT) begin
            addr_count_next = addr_count + 6'd1;
            list[0] = '{kind: addr_kind, value: {56'd0, text_byte}, last: 1'b0};
          end else begin
            list[0] = '{kind: addr_kind + 4'd1, value: {58'd0, addr_count}, last: 1'b0};
            addr_count_next = '0;
            phase_next = phase_t'(phase + 4'd1);
          end
        end
        PH_DATA: begin
          if (data_remaining == 32'd0) begin
            list[0] = '{kind: KIND_DONE, value: 64'd0, last: 1'b0};
            n = 2'd1;
            phase_next = PH_SEC;
            acc_next = '0;
            addr_count_next = '0;
            nibble_seen_next = 1'b0;
            high_nibble_next = '0;
          end else if (is_hex) begin
            if (!nibble_seen) begin
              high_nibble_next = hex_val;
              nibble_seen_next = 1'b1;
            end else begin
              list[0] = '{kind: KIND_DATA, value: {56'd0, high_nibble, hex_val},
                          last: 1'b0};
              n = 2'd1;
              nibble_seen_next = 1'b0;
              high_nibble_next = '0;
              data_remaining_next = data_remaining - 32'd1;
            end
          end else begin
            // early end of data: pending byte, zero fill run, done
            if (nibble_seen) begin
              list[n] = '{kind: KIND_DATA, value: {56'd0, high_nibble, 4'd0}, last: 1'b0};
              n = n + 2'd1;
            end
            if (rem_after != 32'd0) begin
              list[n] = '{kind: KIND_FILL, value: {32'd0, rem_after}, last: 1'b0};
              n = n + 2'd1;
            end
            list[n] = '{kind: KIND_DONE, value: 64'd0, last: 1'b0};
            n = n + 2'd1;
            phase_next = PH_SEC;
            acc_next = '0;
            addr_count_next = '0;
            data_remaining_next = '0;
            nibble_seen_next = 1'b0;
            high_nibble_next = '0;
          end
        end
        PH_SEC, PH_USEC, PH_ETH, PH_PORT, PH_PROTO, PH_LEN: begin
          if (is_digit) begin
            acc_next = acc_step;
          end else begin
            case (phase)
              PH_SEC:   list[0].kind = KIND_SEC;
              PH_USEC:  list[0].kind = KIND_USEC;
              PH_ETH:   list[0].kind = KIND_ETH;
              PH_PORT:  list[0].kind = KIND_PORT;
              PH_PROTO: list[0].kind = KIND_PROTO;
              default:  list[0].kind = KIND_LENGTH;
            endcase
            list[0].value = acc;
            n = 2'd1;
            if (phase == PH_LEN) begin
              data_remaining_next = acc[31:0];
            end
            acc_next = '0;
            nibble_seen_next = 1'b0;
            high_nibble_next = '0;
            phase_next = phase_t'(phase + 4'd1);
          end
        end
        default: begin
          // unreachable codes start a fresh record
          addr_count_next = '0;
          data_remaining_next = '0;
          nibble_seen_next = 1'b0;
          high_nibble_next = '0;
          if (is_digit) begin
            phase_next = PH_SEC;
            acc_next = {60'd0, text_byte[3:0]};
          end else begin
            list[0] = '{kind: KIND_SEC, value: 64'd0, last: 1'b0};
            n = 2'd1;
            phase_next = PH_USEC;
            acc_next = '0;
          end
        end
      endcase
    end

    for (int i = 0; i < RES_MAX; i++) begin
      if (2'(i + 1) == n) begin
        list[i].last = 1'b1;
      end
    end
  end

  assign res_count = take ? n : 2'd0;
  assign res       = list;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SEC;
      acc            <= '0;
      addr_count     <= '0;
      data_remaining <= '0;
      nibble_seen    <= 1'b0;
      high_nibble    <= '0;
    end else if (take) begin
      phase          <= phase_next;
      acc            <= acc_next;
      addr_count     <= addr_count_next;
      data_remaining <= data_remaining_next;
      nibble_seen    <= nibble_seen_next;
      high_nibble    <= high_nibble_next;
    end
  end

`ifndef SYNTH
  a_reset_phase: assert property (@(posedge clk) rst |=> phase == PH_SEC && acc == 64'd0)
    else $error("phase not cleared by reset");
  a_addr_limit: assert property (@(posedge clk) disable iff (rst)
    addr_count <= ADDR_LIMIT)
    else $error("address character count past limit");
  a_nibble_needs_room: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA && nibble_seen) |-> data_remaining != 32'd0)
    else $error("half byte held with no data remaining");
  a_abort_clears: assert property (@(posedge clk) disable iff (rst)
    (take && end_of_input) |=> phase == PH_SEC && !nibble_seen && data_remaining == 32'd0)
    else $error("end of input did not drop the record");
`endif

endmodule
`default_nettype wire

FILE: rtl/trp_result_queue.sv
`default_nettype none
module trp_result_queue (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [1:0]                          push_count,
  input  wire trp_pkg::result_t [trp_pkg::RES_MAX-1:0] push_data,
  output logic                                     room,
  output logic                                     head_valid,
  output trp_pkg::result_t                         head,
  input  wire logic                                pop
);
  import trp_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_pop;

  // room for a whole step's worth of results
  assign room       = count <= CNT_W'(QUEUE_DEPTH - RES_MAX);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      for (int j = 0; j < RES_MAX; j++) begin
        if (2'(j) < push_count && QPTR_W'(wr_ptr + QPTR_W'(j)) == QPTR_W'(i)) begin
          entries[i] <= push_data[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      rd_ptr <= rd_ptr + QPTR_W'(do_pop);
      count  <= count + CNT_W'(push_count) - CNT_W'(do_pop);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");
  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> room)
    else $error("results written without room");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    QPTR_W'(rd_ptr + QPTR_W'(count)) == wr_ptr)
    else $error("queue pointers and count disagree");
`endif

endmodule
`default_nettype wire

FILE: verif/trace_record_text_parser_core_tb.sv
`default_nettype none
module trace_record_text_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trp_pkg::*;

  localparam int ADDR_MAX_CHARS = 46;
  localparam int HOLD_CYCLES    = 200;

  typedef enum logic [3:0] {
    REC_SEC, REC_USEC, REC_ETH, REC_SRC, REC_DST, REC_PORT, REC_PROTO, REC_LEN, REC_DATA
  } rec_phase_t;

  logic clk;
  logic rst;

  trp_in_if  text_if ();
  trp_out_if result_if ();

  trace_record_text_parser_core #(
    .ADDR_MAX_CHARS(ADDR_MAX_CHARS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .result(result_if)
  );

  // parser state as predicted from the accepted text words
  rec_phase_t  rec_phase;
  logic [63:0] dec_acc;
  logic [5:0]  addr_cnt;
  logic [31:0] data_left;
  logic        nib_held;
  logic [3:0]  high_nib;

  result_t pending_results[$];

  int send_idle_pct;
  int stall_pct;
  int hold_seq;
  int errors;
  int words_sent;
  int results_checked;
  int records_sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      v = 4'(c - CH_ZERO);
      return 1'b1;
    end
    if (c inside {[CH_UP_A:CH_UP_F]}) begin
      v = 4'(c - CH_UP_A + 8'd10);
      return 1'b1;
    end
    if (c inside {[CH_LO_A:CH_LO_F]}) begin
      v = 4'(c - CH_LO_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t mk_result(input logic [3:0] kind, input logic [63:0] value);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic [3:0] field_kind(input rec_phase_t ph);
    case (ph)
      REC_SEC:   return KIND_SEC;
      REC_USEC:  return KIND_USEC;
      REC_ETH:   return KIND_ETH;
      REC_PORT:  return KIND_PORT;
      REC_PROTO: return KIND_PROTO;
      default:   return KIND_LENGTH;
    endcase
  endfunction

  function automatic void clear_record();
    rec_phase = REC_SEC;
    dec_acc   = 64'd0;
    addr_cnt  = 6'd0;
    data_left = 32'd0;
    nib_held  = 1'b0;
    high_nib  = 4'h0;
  endfunction

  // works out the result words of one accepted text word
  function automatic void parse_text_word(input logic [7:0] c, input logic eoi);
    result_t    step_q[$];
    logic [3:0] nib;
    bit         is_hex;
    bit         addr_ok;
    is_hex  = hex_nibble(c, nib);
    addr_ok = (is_hex || (c inside {CH_COLON, CH_DOT})) && addr_cnt < ADDR_MAX_CHARS;
    if (eoi) begin
      clear_record();
      step_q.push_back(mk_result(KIND_ABORT, 64'd0));
    end else begin
      case (rec_phase)
        REC_SRC, REC_DST: begin
          if (addr_ok) begin
            addr_cnt = addr_cnt + 6'd1;
            step_q.push_back(mk_result(rec_phase == REC_SRC ? KIND_SRC_CHAR : KIND_DST_CHAR,
                                       {56'd0, c}));
          end else begin
            step_q.push_back(mk_result(rec_phase == REC_SRC ? KIND_SRC_END : KIND_DST_END,
                                       {58'd0, addr_cnt}));
            addr_cnt  = 6'd0;
            rec_phase = rec_phase_t'(rec_phase + 4'd1);
          end
        end
        REC_DATA: begin
          if (data_left == 32'd0) begin
            // every byte read: this word is the newline, whatever it is
            step_q.push_back(mk_result(KIND_DONE, 64'd0));
            clear_record();
          end else if (is_hex) begin
            if (!nib_held) begin
              high_nib = nib;
              nib_held = 1'b1;
            end else begin
              step_q.push_back(mk_result(KIND_DATA, {56'd0, high_nib, nib}));
              nib_held  = 1'b0;
              high_nib  = 4'h0;
              data_left = data_left - 32'd1;
            end
          end else begin
            // short data section: flush a held nibble, zero-fill the rest
            if (nib_held) begin
              step_q.push_back(mk_result(KIND_DATA, {56'd0, high_nib, 4'h0}));
              data_left = data_left - 32'd1;
            end
            if (data_left != 32'd0)
              step_q.push_back(mk_result(KIND_FILL, {32'd0, data_left}));
            step_q.push_back(mk_result(KIND_DONE, 64'd0));
            clear_record();
          end
        end
        default: begin
          if (c inside {[CH_ZERO:CH_NINE]}) begin
            dec_acc = dec_acc * 64'd10 + {56'd0, c - CH_ZERO};
          end else begin
            step_q.push_back(mk_result(field_kind(rec_phase), dec_acc));
            if (rec_phase == REC_LEN)
              data_left = dec_acc[31:0];
            dec_acc   = 64'd0;
            nib_held  = 1'b0;
            high_nib  = 4'h0;
            rec_phase = rec_phase_t'(rec_phase + 4'd1);
          end
        end
      endcase
    end
    if (step_q.size() > 0)
      step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i])
      pending_results.push_back(step_q[i]);
  endfunction

  task automatic send_text(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid        <= 1'b1;
    text_if.text_byte    <= b;
    text_if.end_of_input <= eoi;
    @(posedge clk);
    while (!text_if.ready)
      @(posedge clk);
    parse_text_word(b, eoi);
    words_sent++;
  endtask

  // a record word that now and then is cut short by end of input
  task automatic send_rec_byte(input logic [7:0] b);
    if ($urandom_range(199) == 0)
      send_text(8'($urandom), 1'b1);
    send_text(b, 1'b0);
  endtask

  function automatic logic [7:0] rand_non_digit();
    logic [7:0] c;
    do c = 8'($urandom); while (c inside {[CH_ZERO:CH_NINE]});
    return c;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    case ($urandom_range(2))
      0:       return CH_ZERO + 8'($urandom_range(9));
      1:       return CH_UP_A + 8'($urandom_range(5));
      default: return CH_LO_A + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    logic [3:0] v;
    do c = 8'($urandom); while (hex_nibble(c, v));
    return c;
  endfunction

  function automatic logic [7:0] rand_addr_char();
    case ($urandom_range(4))
      0:       return CH_COLON;
      1:       return CH_DOT;
      default: return rand_hex_char();
    endcase
  endfunction

  function automatic logic [7:0] rand_non_addr();
    logic [7:0] c;
    do c = rand_non_hex(); while (c inside {CH_COLON, CH_DOT});
    return c;
  endfunction

  task automatic send_decimal_field();
    int n;
    // long runs of digits wrap the accumulator
    n = ($urandom_range(23) == 0) ? $urandom_range(20, 24) : $urandom_range(0, 2);
    repeat (n) send_rec_byte(CH_ZERO + 8'($urandom_range(9)));
    send_rec_byte(rand_non_digit());
  endtask

  task automatic send_address();
    int n;
    n = ($urandom_range(15) == 0) ? ADDR_MAX_CHARS : $urandom_range(0, 3);
    repeat (n) send_rec_byte(rand_addr_char());
    // a full address ends on any word, even one that looks like an address char
    if (n == ADDR_MAX_CHARS && $urandom_range(1))
      send_rec_byte(rand_addr_char());
    else
      send_rec_byte(rand_non_addr());
  endtask

  task automatic send_length_and_data();
    int unsigned len;
    int          k;
    string       digits;
    len = ($urandom_range(14) == 0) ? $urandom_range(100, 100000) : $urandom_range(0, 4);
    digits = $sformatf("%0d", len);
    if ($urandom_range(7) == 0)
      send_rec_byte(CH_ZERO);
    for (int i = 0; i < digits.len(); i++)
      send_rec_byte(digits[i]);
    send_rec_byte(rand_non_digit());
    if (len <= 6 && $urandom_range(3) != 0) begin
      repeat (len) begin
        send_rec_byte(rand_hex_char());
        send_rec_byte(rand_hex_char());
      end
      send_rec_byte($urandom_range(1) ? 8'h0a : 8'($urandom));
    end else begin
      // data section may end early, maybe on a lone high nibble
      k = $urandom_range(0, (len < 3) ? len : 3);
      repeat (k) begin
        send_rec_byte(rand_hex_char());
        send_rec_byte(rand_hex_char());
      end
      if ($urandom_range(1))
        send_rec_byte(rand_hex_char());
      send_rec_byte(rand_non_hex());
    end
  endtask

  task automatic send_record();
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(1, 4)) send_text(8'($urandom), 1'b0);
    repeat (3) send_decimal_field();
    send_address();
    send_address();
    repeat (2) send_decimal_field();
    send_length_and_data();
    records_sent++;
  endtask

  task automatic run_random_records(input int min_words);
    int start;
    start = words_sent;
    while (words_sent - start < min_words)
      send_record();
  endtask

  task automatic test_directed_fields();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_text(8'h00, 1'b0);                       // empty seconds
    send_text("9", 1'b0);
    send_text(8'hff, 1'b0);
    send_text("0", 1'b0);
    send_text("/", 1'b0);
    send_text("f", 1'b0);
    send_text("A", 1'b0);
    send_text(":", 1'b0);
    send_text(".", 1'b0);
    send_text("G", 1'b0);
    send_text(" ", 1'b0);                         // empty destination
    send_text("1", 1'b0);
    send_text(":", 1'b0);
    send_text(";", 1'b0);
    send_text("3", 1'b0);
    send_text(" ", 1'b0);
    send_text("a", 1'b0);
    send_text("F", 1'b0);
    send_text("0", 1'b0);
    send_text(8'h0a, 1'b0);                       // held nibble, fill and done
    records_sent++;
  endtask

  task automatic test_abort();
    send_text(8'hff, 1'b1);                       // end of input at record start
    send_text("7", 1'b0);
    send_text(8'h35, 1'b1);                       // end of input mid field
    send_text(8'h00, 1'b0);
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int min_words);
    send_idle_pct = idle;
    stall_pct     = stall;
    run_random_records(min_words);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_seq++;
    run_random_records(24);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected: kind %0d value %h last %b", $time,
                 result_if.result_kind, result_if.result_value, result_if.last_of_step);
      end else begin
        want = pending_results.pop_front();
        if (result_if.result_kind !== want.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                   result_if.result_kind);
        end
        if (result_if.result_value !== want.value) begin
          errors++;
          $display("%0t: value expected %h actual %h", $time, want.value,
                   result_if.result_value);
        end
        if (result_if.last_of_step !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last,
                   result_if.last_of_step);
        end
      end
    end
  end

  initial begin
    int waited;
    errors          = 0;
    words_sent      = 0;
    results_checked = 0;
    records_sent    = 0;
    hold_seq        = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    clear_record();
    rst                  <= 1'b1;
    text_if.valid        <= 1'b0;
    text_if.text_byte    <= 8'h00;
    text_if.end_of_input <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_fields();
    test_abort();
    test_random_phase(50, 0, 24);
    test_random_phase(0, 50, 24);
    test_random_phase(17, 17, 24);
    test_backpressure();

    text_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0t: %0d expected result words never arrived, next kind %0d value %h",
               $time, pending_results.size(), pending_results[0].kind,
               pending_results[0].value);
    end

    $display("sent %0d text words in %0d records, checked %0d result words", words_sent,
             records_sent, results_checked);
    $display("ran directed field, address and data ends and aborts, then random records");
    $display("under sender idling, result stalls, both, and one long result hold");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/trp_pkg.sv
rtl/trp_in_if.sv
rtl/trp_out_if.sv
rtl/trp_step.sv
rtl/trp_result_queue.sv
rtl/trace_record_text_parser_core.sv
verif/trace_record_text_parser_core_tb.sv
